/* rtl/core/bright_excluded_white_balance_assert.svh */
// Assertion macros shared by the checker of the white balance block.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef BRIGHT_EXCLUDED_WHITE_BALANCE_ASSERT_SVH
`define BRIGHT_EXCLUDED_WHITE_BALANCE_ASSERT_SVH

// Same-cycle implication, switched off during reset.
`define BEWB_AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bewb assertion failed");

// Next-cycle implication, switched off during reset.
`define BEWB_AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bewb assertion failed");

// Next-cycle implication that is also checked while reset is applied.
`define BEWB_AST_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("bewb assertion failed");

`endif

/* rtl/core/bewb_pkg.sv */
// Package of the white balance block: payload structs, control structs, constants.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package bewb_pkg;

    localparam int YK_W      = 18;
    localparam int BIN_W     = 8;
    localparam int NUM_BINS  = 256;
    localparam int PCT_W     = 7;
    localparam int CH_W      = 8;
    localparam int RECIP_W   = 19;
    localparam int RECIP_SH  = 28;
    localparam int LIM_W     = PCT_W + YK_W;
    localparam int DIV_STEPS = 8;

    localparam logic [9:0]         COEF_R    = 10'd299;
    localparam logic [9:0]         COEF_G    = 10'd587;
    localparam logic [9:0]         COEF_B    = 10'd114;
    localparam logic [9:0]         BIN_DIV   = 10'd1000;
    localparam logic [RECIP_W-1:0] BIN_RECIP = 19'd268435;
    localparam logic [LIM_W-1:0]   BIN_STEP  = 25'd100000;
    localparam logic [PCT_W-1:0]   PCT_RESET = 7'd95;
    localparam logic [CH_W-1:0]    CH_MAX    = 8'd255;

    localparam logic OP_GATHER = 1'b0;
    localparam logic OP_APPLY  = 1'b1;

    typedef struct packed {
        logic            operation;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] red_out;
        logic            status;
    } t_pix_out;

    typedef struct packed {
        logic capture;
        logic new_frame;
        logic calc_yk;
        logic calc_q;
        logic bin_rd;
        logic bin_wr;
        logic walk_init;
        logic walk_rd;
        logic walk_acc;
        logic prod;
        logic den;
        logic mul_num;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic apply_phase;
        logic full;
        logic last_bin;
        logic div_last;
    } t_sts;

endpackage

/* rtl/core/bewb_ctrl.sv */
// Controller of the white balance block: sequences gather, bin walk and correction.
// Depends on bewb_pkg for the command and status structs.
`timescale 1ns / 1ps

module bewb_ctrl import bewb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_YK, S_QA, S_BIN, S_WR, S_LIM, S_WRD, S_WACC,
        S_PROD, S_DEN, S_NUM, S_DINIT, S_DIV, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_slot_free;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = w_accept;
                if (w_accept) n_state = S_DISP;
            end
            S_DISP: begin
                if (i_sts.op == OP_GATHER) begin
                    o_cmd.new_frame = i_sts.apply_phase;
                    n_state = S_YK;
                end else if (i_sts.apply_phase) begin
                    n_state = S_NUM;
                end else begin
                    n_state = S_LIM;
                end
            end
            S_YK: begin
                o_cmd.calc_yk = 1'b1;
                n_state = i_sts.full ? S_IDLE : S_QA;
            end
            S_QA: begin
                o_cmd.calc_q = 1'b1;
                n_state = S_BIN;
            end
            S_BIN: begin
                o_cmd.bin_rd = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.bin_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_LIM: begin
                o_cmd.walk_init = 1'b1;
                n_state = S_WRD;
            end
            S_WRD: begin
                o_cmd.walk_rd = 1'b1;
                n_state = S_WACC;
            end
            S_WACC: begin
                o_cmd.walk_acc = 1'b1;
                n_state = i_sts.last_bin ? S_PROD : S_WRD;
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state = S_DEN;
            end
            S_DEN: begin
                o_cmd.den = 1'b1;
                n_state = S_NUM;
            end
            S_NUM: begin
                o_cmd.mul_num = 1'b1;
                n_state = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.out_load = w_slot_free;
                if (w_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/core/bewb_dp.sv */
// Datapath of the white balance block: statistics, bin store, walk, divider.
// Depends on bewb_pkg; driven by bewb_ctrl through t_cmd and t_sts.
`timescale 1ns / 1ps

module bewb_dp import bewb_pkg::*; #(
    parameter int MAX_PIXELS = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  t_pix_in          i_pix,
    input  logic             i_cfg_valid,
    input  logic [PCT_W-1:0] i_cfg_data,
    output t_pix_out         o_pix
);

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int LSUM_W = $clog2(64'(MAX_PIXELS) * 64'd255000 + 64'd1);
    localparam int CSUM_W = $clog2(64'(MAX_PIXELS) * 64'd255 + 64'd1);
    localparam int P_W    = LSUM_W + CNT_W;
    localparam int ND_W   = CNT_W + 10;
    localparam int D_W    = ND_W + CSUM_W;
    localparam int NUM_W  = P_W + CH_W;
    localparam int W      = (NUM_W > D_W + CH_W) ? NUM_W : D_W + CH_W;
    localparam int K_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [CSUM_W-1:0] bsum;
        logic [CSUM_W-1:0] gsum;
        logic [CSUM_W-1:0] rsum;
    } t_entry;

    t_entry r_mem [NUM_BINS];
    logic [NUM_BINS-1:0] r_valid;

    logic [PCT_W-1:0]  r_keep_percent;
    t_pix_in           r_pix;
    logic              r_phase;
    logic [LSUM_W-1:0] r_lsum;
    logic [YK_W-1:0]   r_lmax;
    logic [CNT_W-1:0]  r_count;
    logic [YK_W-1:0]   r_yk;
    logic [BIN_W:0]    r_qa;
    logic [BIN_W-1:0]  r_bin;
    t_entry            r_rd;
    logic              r_rd_vld;
    logic [LIM_W-1:0]  r_limit;
    logic [LIM_W-1:0]  r_thr;
    logic [BIN_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_kcnt;
    logic [CSUM_W-1:0] r_ksum [3];
    logic [P_W-1:0]    r_prod;
    logic [ND_W-1:0]   r_nd;
    logic [D_W-1:0]    r_den [3];
    logic [2:0]        r_kzero;
    logic [NUM_W-1:0]  r_num [3];
    logic [W-1:0]      r_rem [3];
    logic [W-1:0]      r_dsh [3];
    logic [CH_W-1:0]   r_q [3];
    logic [2:0]        r_sat;
    logic [K_W-1:0]    r_div_k;
    t_pix_out          r_out;

    logic [YK_W-1:0]          w_yk;
    logic [YK_W+RECIP_W-1:0]  w_qprod;
    logic [YK_W-1:0]          w_rem;
    logic [BIN_W:0]           w_bin_full;
    logic [BIN_W-1:0]         w_bin;
    logic [BIN_W-1:0]         w_rd_addr;
    t_entry                   w_entry;
    logic [CH_W-1:0]          w_ch [3];
    logic [CSUM_W-1:0]        w_bin_sum [3];
    logic [CH_W-1:0]          w_res [3];
    logic                     w_pass;

    assign w_ch[0] = r_pix.blue;
    assign w_ch[1] = r_pix.green;
    assign w_ch[2] = r_pix.red;
    assign w_bin_sum[0] = r_rd.bsum;
    assign w_bin_sum[1] = r_rd.gsum;
    assign w_bin_sum[2] = r_rd.rsum;

    assign w_yk = YK_W'(COEF_R) * YK_W'(r_pix.red) + YK_W'(COEF_G) * YK_W'(r_pix.green)
                + YK_W'(COEF_B) * YK_W'(r_pix.blue);
    assign w_qprod = (YK_W+RECIP_W)'(r_yk) * (YK_W+RECIP_W)'(BIN_RECIP);
    // Reciprocal quotient may fall one short; a single compare fixes it.
    assign w_rem = r_yk - YK_W'(r_qa) * YK_W'(BIN_DIV);
    assign w_bin_full = (w_rem >= YK_W'(BIN_DIV)) ? r_qa + 1'b1 : r_qa;
    assign w_bin = w_bin_full[BIN_W-1:0];
    assign w_rd_addr = i_cmd.bin_rd ? w_bin : r_idx;

    always_comb begin
        w_entry = r_rd_vld ? r_rd : '0;
        w_entry.cnt  = w_entry.cnt + 1'b1;
        w_entry.bsum = w_entry.bsum + CSUM_W'(r_pix.blue);
        w_entry.gsum = w_entry.gsum + CSUM_W'(r_pix.green);
        w_entry.rsum = w_entry.rsum + CSUM_W'(r_pix.red);
    end

    assign w_pass = (r_kcnt == '0);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_pass) w_res[i] = w_ch[i];
            else if (r_kzero[i]) w_res[i] = (w_ch[i] != '0) ? CH_MAX : '0;
            else if (r_sat[i]) w_res[i] = CH_MAX;
            else w_res[i] = r_q[i];
        end
    end

    assign o_sts.op          = r_pix.operation;
    assign o_sts.apply_phase = r_phase;
    assign o_sts.full        = (r_count >= CNT_W'(MAX_PIXELS));
    assign o_sts.last_bin    = (r_idx == BIN_W'(NUM_BINS - 1));
    assign o_sts.div_last    = (r_div_k == '0);
    assign o_pix             = r_out;

    // Bin store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.bin_wr) r_mem[r_bin] <= w_entry;
        if (i_cmd.bin_rd || i_cmd.walk_rd) r_rd <= r_mem[w_rd_addr];
    end

    // Control state and frame statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_percent <= PCT_RESET;
            r_phase  <= 1'b0;
            r_lsum   <= '0;
            r_lmax   <= '0;
            r_count  <= '0;
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
            r_div_k  <= '0;
        end else begin
            if (i_cfg_valid) r_keep_percent <= i_cfg_data;
            if (i_cmd.new_frame) begin
                r_phase <= 1'b0;
                r_lsum  <= '0;
                r_lmax  <= '0;
                r_count <= '0;
                r_valid <= '0;
            end
            if (i_cmd.calc_q) begin
                r_lsum  <= r_lsum + LSUM_W'(r_yk);
                if (r_yk > r_lmax) r_lmax <= r_yk;
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.bin_wr) r_valid[r_bin] <= 1'b1;
            if (i_cmd.bin_rd || i_cmd.walk_rd) r_rd_vld <= r_valid[w_rd_addr];
            if (i_cmd.den) r_phase <= 1'b1;
            if (i_cmd.div_init) r_div_k <= K_W'(DIV_STEPS - 1);
            else if (i_cmd.div_step) r_div_k <= r_div_k - 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_pix <= i_pix;
        if (i_cmd.calc_yk) r_yk <= w_yk;
        if (i_cmd.calc_q) r_qa <= w_qprod[RECIP_SH +: BIN_W+1];
        if (i_cmd.bin_rd) r_bin <= w_bin;
        if (i_cmd.walk_init) begin
            r_limit <= LIM_W'(r_keep_percent) * LIM_W'(r_lmax);
            r_thr   <= '0;
            r_idx   <= '0;
            r_kcnt  <= '0;
            for (int i = 0; i < 3; i++) r_ksum[i] <= '0;
        end
        if (i_cmd.walk_acc) begin
            if (r_rd_vld && (r_thr <= r_limit)) begin
                r_kcnt <= r_kcnt + r_rd.cnt;
                for (int i = 0; i < 3; i++) r_ksum[i] <= r_ksum[i] + w_bin_sum[i];
            end
            r_thr <= r_thr + BIN_STEP;
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.prod) begin
            r_prod <= P_W'(r_lsum) * P_W'(r_kcnt);
            r_nd   <= ND_W'(r_count) * ND_W'(BIN_DIV);
        end
        if (i_cmd.den) begin
            for (int i = 0; i < 3; i++) begin
                r_den[i]   <= D_W'(r_nd) * D_W'(r_ksum[i]);
                r_kzero[i] <= (r_ksum[i] == '0);
            end
        end
        if (i_cmd.mul_num) begin
            for (int i = 0; i < 3; i++) r_num[i] <= NUM_W'(r_prod) * NUM_W'(w_ch[i]);
        end
        if (i_cmd.div_init) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= W'(r_num[i]);
                r_dsh[i] <= W'(r_den[i]) << (DIV_STEPS - 1);
                r_sat[i] <= (W'(r_num[i]) >= (W'(r_den[i]) << DIV_STEPS));
                r_q[i]   <= '0;
            end
        end
        if (i_cmd.div_step) begin
            for (int i = 0; i < 3; i++) begin
                if (r_rem[i] >= r_dsh[i]) r_rem[i] <= r_rem[i] - r_dsh[i];
                r_q[i]   <= {r_q[i][CH_W-2:0], (r_rem[i] >= r_dsh[i])};
                r_dsh[i] <= r_dsh[i] >> 1;
            end
        end
        if (i_cmd.out_load) begin
            r_out.blue_out  <= w_res[0];
            r_out.green_out <= w_res[1];
            r_out.red_out   <= w_res[2];
            r_out.status    <= w_pass;
        end
    end

endmodule

/* rtl/core/bright_excluded_white_balance.sv */
// Top level of the bright-excluded gray-world white balance block.
// Instantiates bewb_ctrl and bewb_dp; depends on bewb_pkg.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                 Payload
//  in        input      i_in_valid / o_in_ready   t_pix_in  (operation, blue, green, red)
//  out       output     o_out_valid / i_out_ready t_pix_out (blue_out .. red_out, status)
//  cfg       input      i_cfg_valid / o_cfg_ready keep_percent, 7 bits
//
//  A gather pixel steps through dispatch, luma, reciprocal quotient, bin read and
//  bin write before the next ready; a pixel beyond the frame limit stops after luma.
//  An apply pixel runs through the 8-step restoring divider shared by nothing else;
//  the first apply pixel of a frame first walks the 256 bins, with one read and one
//  accumulate state per bin, plus setup and products.
//  Reset is synchronous; bin valid bits clear at once, so no clearing pass is needed.
//  A finished result waits in the output register while the next pixel is taken in;
//  the next apply pixel stalls in its last cycle until that register is free.

module bright_excluded_white_balance import bewb_pkg::*; #(
    parameter int MAX_PIXELS = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_pix_in          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_pix_out         o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [PCT_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // The register is a plain flop, so a configuration transfer is always taken.
    assign o_cfg_ready = 1'b1;

    // The controller owns the handshakes and steps the datapath one phase at a time.
    bewb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the statistics, the bin store, the walk and the divider.
    bewb_dp #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_pix       (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_pix       (o_out_data)
    );

endmodule

/* rtl/core/bewb_chk.sv */
// Port-level checker for the white balance block, bound to the top level.
// Depends on bewb_pkg and bright_excluded_white_balance_assert.svh.
`timescale 1ns / 1ps
`include "bright_excluded_white_balance_assert.svh"

module bewb_chk import bewb_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input t_pix_in          i_in_data,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input t_pix_out         o_out_data,
    input logic             i_cfg_valid,
    input logic             o_cfg_ready,
    input logic [PCT_W-1:0] i_cfg_data
);

    `BEWB_AST_NEXT_RST(a_out_idle_after_reset, !i_rst_n, !o_out_valid)
    `BEWB_AST_NEXT(a_one_item_at_a_time, i_in_valid && o_in_ready, !o_in_ready)
    `BEWB_AST_NEXT(a_gather_no_result, i_in_valid && o_in_ready && !i_in_data.operation, !$rose(o_out_valid))
    `BEWB_AST_NEXT(a_out_held, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    `BEWB_AST_SAME(a_cfg_always_taken, i_cfg_valid, o_cfg_ready)

endmodule

bind bright_excluded_white_balance bewb_chk u_chk (.*);

/* sim/bright_excluded_white_balance_checker.sv */
// Checker of the white balance block: watches the three channels, predicts each result.
// Depends on bewb_pkg for the payload types and the operation codes.
`timescale 1ns / 1ps

module bright_excluded_white_balance_checker import bewb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_pix_in          i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_pix_out         i_out_data,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [PCT_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results_seen
);

    localparam int unsigned FRAME_LIMIT = 65536;

    logic [16:0] bin_count [NUM_BINS];
    logic [23:0] bin_sum_b [NUM_BINS];
    logic [23:0] bin_sum_g [NUM_BINS];
    logic [23:0] bin_sum_r [NUM_BINS];
    logic [33:0] luma_sum;
    logic [17:0] luma_peak;
    logic [16:0] frame_count;
    logic [16:0] kept_count;
    logic [23:0] kept_b, kept_g, kept_r;
    logic        applying;
    logic [PCT_W-1:0] keep_pct;
    t_pix_out    expected_pixels [$];

    function automatic logic [7:0] scale_channel(logic [7:0] c, logic [23:0] ksum);
        logic [63:0] num, den, q;
        if (ksum == 0) return (c > 0) ? CH_MAX : 8'd0;
        num = 64'(luma_sum) * 64'(kept_count) * 64'(c);
        den = 64'd1000 * 64'(frame_count) * 64'(ksum);
        if (den == 0) return 8'd0;
        q = num / den;
        return (q > 255) ? CH_MAX : q[7:0];
    endfunction

    task automatic clear_frame();
        for (int b = 0; b < NUM_BINS; b++) begin
            bin_count[b] = '0;
            bin_sum_b[b] = '0;
            bin_sum_g[b] = '0;
            bin_sum_r[b] = '0;
        end
        luma_sum = '0;
        luma_peak = '0;
        frame_count = '0;
        kept_count = '0;
        kept_b = '0;
        kept_g = '0;
        kept_r = '0;
        applying = 1'b0;
    endtask

    task automatic predict_pixel(t_pix_in px);
        logic [17:0] yk;
        logic [7:0]  bin;
        logic [63:0] limit;
        t_pix_out    res;
        if (px.operation == OP_GATHER) begin
            if (applying) clear_frame();
            if (frame_count < FRAME_LIMIT) begin
                yk = 18'(COEF_R) * 18'(px.red) + 18'(COEF_G) * 18'(px.green)
                   + 18'(COEF_B) * 18'(px.blue);
                bin = 8'(yk / 1000);
                luma_sum += 34'(yk);
                if (yk > luma_peak) luma_peak = yk;
                frame_count++;
                bin_count[bin]++;
                bin_sum_b[bin] += 24'(px.blue);
                bin_sum_g[bin] += 24'(px.green);
                bin_sum_r[bin] += 24'(px.red);
            end
        end else begin
            // The first apply pixel of a frame sums up the bins under the luma cut.
            if (!applying) begin
                limit = 64'(keep_pct) * 64'(luma_peak);
                kept_count = '0;
                kept_b = '0;
                kept_g = '0;
                kept_r = '0;
                for (int b = 0; b < NUM_BINS; b++) begin
                    if (64'(b) * 64'd100000 <= limit) begin
                        kept_count += bin_count[b];
                        kept_b += bin_sum_b[b];
                        kept_g += bin_sum_g[b];
                        kept_r += bin_sum_r[b];
                    end
                end
                applying = 1'b1;
            end
            if (kept_count == 0 || frame_count == 0) begin
                res = '{blue_out: px.blue, green_out: px.green, red_out: px.red, status: 1'b1};
            end else begin
                res.blue_out  = scale_channel(px.blue, kept_b);
                res.green_out = scale_channel(px.green, kept_g);
                res.red_out   = scale_channel(px.red, kept_r);
                res.status    = 1'b0;
            end
            expected_pixels.push_back(res);
        end
    endtask

    task automatic compare_pixel(t_pix_out got);
        t_pix_out want;
        if (expected_pixels.size() == 0) begin
            $error("unexpected result transfer: %p", got);
            o_fail_count++;
            return;
        end
        want = expected_pixels.pop_front();
        if (got.blue_out !== want.blue_out) begin
            $error("blue_out expected %0d actual %0d", want.blue_out, got.blue_out);
            o_fail_count++;
        end
        if (got.green_out !== want.green_out) begin
            $error("green_out expected %0d actual %0d", want.green_out, got.green_out);
            o_fail_count++;
        end
        if (got.red_out !== want.red_out) begin
            $error("red_out expected %0d actual %0d", want.red_out, got.red_out);
            o_fail_count++;
        end
        if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_results_seen = 0;
        o_pending = 0;
        keep_pct = PCT_RESET;
        clear_frame();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            keep_pct = PCT_RESET;
            expected_pixels.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                compare_pixel(i_out_data);
                o_results_seen++;
            end
            if (i_cfg_valid && i_cfg_ready) keep_pct = i_cfg_data;
            if (i_in_valid && i_in_ready) predict_pixel(i_in_data);
        end
        o_pending = expected_pixels.size();
    end

endmodule

/* sim/bright_excluded_white_balance_test.sv */
// Top of the white balance testbench: clock, reset, stimulus and the verdict.
// Depends on bewb_pkg, the block and bright_excluded_white_balance_checker.
`timescale 1ns / 1ps

module bright_excluded_white_balance_test;
    import bewb_pkg::*;

    // Generous bound: sized so that even a run in which every pixel were an apply that
    // walks the bins under heavy output stalls would stay inside it.
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RANDOM_PIXELS = 1400;

    logic             i_clk;
    logic             i_rst_n;
    logic             in_valid;
    logic             in_ready;
    t_pix_in          in_data;
    logic             out_valid;
    logic             out_ready;
    t_pix_out         out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [PCT_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    int               results_seen;
    int               cycle_count;
    int               frames_sent;
    int               cfg_writes;
    bit               steady;       // no idling on either side while set
    bit               hold_request; // asks the receiver for one long hold-off
    bit               hold_sent;    // the long hold-off has been asked for
    int               hold_left;

    bright_excluded_white_balance u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    bright_excluded_white_balance_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Cycle counter and watchdog. A hang anywhere ends the run as a failure.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver side. Ready drops in about a third of the cycles unless the run is
    // in a steady stretch. One long hold-off lets the block back up and stall its input.
    initial hold_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 3000;
            out_ready <= 1'b0;
        end else if (steady) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= 35);
        end
    end

    // Offers one pixel. Valid stays high across back-to-back transfers; within this task
    // it only falls when a random gap is taken before the next pixel.
    task automatic send_pixel(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        if (!steady && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 35);
        end
        in_valid <= 1'b1;
        in_data  <= '{operation: op, blue: b, green: g, red: r};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Picks a channel value, leaning toward the ends of the range.
    function automatic logic [7:0] pick_level();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Waits until every result is back and the last gathers have drained, then
    // writes the percent register.
    task automatic write_percent(logic [PCT_W-1:0] pct);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= pct;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic random_frame(int gathers, int applies);
        for (int k = 0; k < gathers; k++)
            send_pixel(OP_GATHER, pick_level(), pick_level(), pick_level());
        for (int k = 0; k < applies; k++)
            send_pixel(OP_APPLY, pick_level(), pick_level(), pick_level());
        frames_sent++;
    endtask

    initial begin
        int sent;
        int gathers;
        int applies;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        steady       = 1'b0;
        hold_request = 1'b0;
        hold_sent    = 1'b0;
        frames_sent  = 0;
        cfg_writes   = 0;
        i_rst_n      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Apply with no frame gathered yet: pixels pass through flagged.
        send_pixel(OP_APPLY, 8'd0, 8'd0, 8'd0);
        send_pixel(OP_APPLY, 8'd255, 8'd255, 8'd255);

        // A frame of extreme pixels under the reset percent.
        send_pixel(OP_GATHER, 8'd0, 8'd0, 8'd0);
        send_pixel(OP_GATHER, 8'd255, 8'd255, 8'd255);
        send_pixel(OP_GATHER, 8'd0, 8'd0, 8'd255);
        send_pixel(OP_GATHER, 8'd0, 8'd255, 8'd0);
        send_pixel(OP_GATHER, 8'd255, 8'd0, 8'd0);
        send_pixel(OP_GATHER, 8'd10, 8'd20, 8'd30);
        send_pixel(OP_APPLY, 8'd0, 8'd0, 8'd0);
        send_pixel(OP_APPLY, 8'd255, 8'd255, 8'd255);
        send_pixel(OP_APPLY, 8'd128, 8'd64, 8'd32);

        // Percent zero keeps only the darkest bin, whose channel sums are all zero,
        // so a lit channel saturates and a dark one stays at zero.
        write_percent(7'd0);
        send_pixel(OP_GATHER, 8'd0, 8'd0, 8'd0);
        send_pixel(OP_GATHER, 8'd200, 8'd200, 8'd200);
        send_pixel(OP_APPLY, 8'd255, 8'd0, 8'd1);

        // Above one hundred every bin is kept.
        write_percent(7'd127);
        send_pixel(OP_GATHER, 8'd255, 8'd255, 8'd255);
        send_pixel(OP_GATHER, 8'd1, 8'd2, 8'd3);
        send_pixel(OP_APPLY, 8'd100, 8'd100, 8'd100);

        write_percent(7'd1);
        send_pixel(OP_GATHER, 8'd5, 8'd5, 8'd5);
        send_pixel(OP_GATHER, 8'd250, 8'd250, 8'd250);
        send_pixel(OP_APPLY, 8'd77, 8'd88, 8'd99);
        write_percent(7'd100);

        // Random frames. Most are well formed, gathers then applies; some are
        // applies only, which continue the current frame, or lone gathers.
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0: write_percent(7'd1);
                    1: write_percent(7'd100);
                    2: write_percent(7'($urandom_range(127)));
                    default: write_percent(7'($urandom_range(1, 100)));
                endcase
            end
            steady = (sent >= 500 && sent < 700);
            if (sent >= 800 && !hold_sent) begin
                hold_request = 1'b1;
                hold_sent = 1'b1;
            end
            case ($urandom_range(9))
                0: begin
                    gathers = 0;
                    applies = $urandom_range(1, 6);
                end
                1: begin
                    gathers = $urandom_range(1, 4);
                    applies = 0;
                end
                default: begin
                    gathers = $urandom_range(1, 40);
                    applies = $urandom_range(1, 20);
                end
            endcase
            random_frame(gathers, applies);
            sent += gathers + applies;
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Covered %0d frames, %0d percent writes, %0d checked results,",
                 frames_sent, cfg_writes, results_seen);
        $display("including pass-through, percent extremes and a long output hold-off.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
